[hdl/crt_pkg.sv]
`default_nettype none

package crt_pkg;

   localparam int TGT_W   = 256;
   localparam int BPS     = 2;
   localparam int NSTAGE  = TGT_W / BPS;
   localparam int MANT_W  = 23;
   localparam int PROD_W  = 87;
   localparam int REM_W   = 25;

   localparam logic [30:0] HEIGHT_SWITCH = 31'd10000;

   localparam logic [1:0] POS_NONE   = 2'd0;
   localparam logic [1:0] POS_FIRST  = 2'd1;
   localparam logic [1:0] POS_SECOND = 2'd2;
   localparam logic [1:0] POS_FULL   = 2'd3;

   localparam logic [2:0] REG_WORK_LIMIT     = 3'd0;
   localparam logic [2:0] REG_STAKE_LIMIT    = 3'd1;
   localparam logic [2:0] REG_SPACING_FIRST  = 3'd2;
   localparam logic [2:0] REG_SPACING_SECOND = 3'd3;
   localparam logic [2:0] REG_TIMESPAN       = 3'd4;

   localparam logic [31:0] RST_WORK_LIMIT  = 32'd486604799;
   localparam logic [31:0] RST_STAKE_LIMIT = 32'd486604799;
   localparam logic [15:0] RST_SPACING     = 16'd60;
   localparam logic [23:0] RST_TIMESPAN    = 24'd1200;

   typedef struct packed {
      logic        started;
      logic        cap;
      logic [4:0]  kb;
      logic [23:0] win;
   } crt_trk_type;

   typedef struct packed {
      logic               valid;
      logic               full;
      logic               hf;
      logic [REM_W-1:0]   d;
      logic [REM_W-1:0]   rem;
      logic [PROD_W-1:0]  dv;
      logic [7:0]         gap;
      logic [MANT_W-1:0]  lsr;
      logic [7:0]         lgap;
      logic               gt;
      logic               lt;
      crt_trk_type        qtrk;
      crt_trk_type        ltrk;
   } crt_stage_type;

   typedef struct packed {
      logic [31:0]             work_limit;
      logic [31:0]             stake_limit;
      logic [1:0][63:0]        base;
      logic [1:0][REM_W-1:0]   d;
      logic [1:0][15:0]        sp;
   } crt_cfg_type;

   function automatic crt_trk_type trk_step(input crt_trk_type t, input logic b,
                                            input logic [7:0] pos);
      crt_trk_type r;
      r = t;
      if (!r.cap) begin
         r.win = {r.win[22:0], b};
      end
      if (!r.started && b) begin
         r.started = 1'b1;
         r.kb      = pos[7:3];
      end
      if (r.started && !r.cap && (pos[2:0] == 3'd0)
          && (({1'b0, pos[7:3]} + 6'd2) == {1'b0, r.kb})) begin
         r.cap = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [31:0] trk_encode(input crt_trk_type t);
      logic [23:0] c;
      logic [7:0]  size;
      c    = t.win;
      size = {3'd0, t.kb} + 8'd1;
      if (!t.cap) begin
         c = (t.kb == 5'd0) ? {t.win[7:0], 16'd0} : {t.win[15:0], 8'd0};
      end
      if (c[23]) begin
         c    = c >> 8;
         size = size + 8'd1;
      end
      if (!t.started) begin
         return 32'd0;
      end
      return {size, 1'b0, c[22:0]};
   endfunction

endpackage

`default_nettype wire

[hdl/crt_cfg.sv]
`default_nettype none

module crt_cfg (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic                cfg_ready,
   output crt_pkg::crt_cfg_type cfg
);
   import crt_pkg::*;

   typedef enum logic [3:0] {
      SEQ_LOAD    = 4'b0001,
      SEQ_DIVIDE  = 4'b0010,
      SEQ_PRODUCT = 4'b0100,
      SEQ_IDLE    = 4'b1000
   } seq_type;

   logic [31:0] work_ff, work_in;
   logic [31:0] stake_ff, stake_in;
   logic [15:0] sp1_ff, sp1_in;
   logic [15:0] sp2_ff, sp2_in;
   logic [23:0] span_ff, span_in;

   seq_type     state_ff, state_in;
   logic        sel_ff, sel_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [1:0][63:0]      base_ff, base_in;
   logic [1:0][REM_W-1:0] d_ff, d_in;

   logic [15:0] sp_eff1, sp_eff2, sp_cur;
   logic [16:0] rtrial;
   logic [39:0] prod;

   assign sp_eff1 = (sp1_ff == 16'd0) ? 16'd1 : sp1_ff;
   assign sp_eff2 = (sp2_ff == 16'd0) ? 16'd1 : sp2_ff;
   assign sp_cur  = sel_ff ? sp_eff2 : sp_eff1;
   assign prod    = quo_ff * sp_cur;

   always_comb begin
      work_in  = work_ff;
      stake_in = stake_ff;
      sp1_in   = sp1_ff;
      sp2_in   = sp2_ff;
      span_in  = span_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WORK_LIMIT:     work_in  = csr_wdata;
            REG_STAKE_LIMIT:    stake_in = csr_wdata;
            REG_SPACING_FIRST:  sp1_in   = csr_wdata[15:0];
            REG_SPACING_SECOND: sp2_in   = csr_wdata[15:0];
            REG_TIMESPAN:       span_in  = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      base_in  = base_ff;
      d_in     = d_ff;
      rtrial   = {rem_ff, quo_ff[23]};
      unique case (state_ff)
         SEQ_LOAD: begin
            rem_in   = 16'd0;
            quo_in   = span_ff;
            cnt_in   = 5'd0;
            state_in = SEQ_DIVIDE;
         end
         SEQ_DIVIDE: begin
            if (rtrial >= {1'b0, sp_cur}) begin
               rtrial = rtrial - {1'b0, sp_cur};
               quo_in = {quo_ff[22:0], 1'b1};
            end else begin
               quo_in = {quo_ff[22:0], 1'b0};
            end
            rem_in = rtrial[15:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               state_in = SEQ_PRODUCT;
            end
         end
         SEQ_PRODUCT: begin
            base_in[sel_ff] = (quo_ff == 24'd0) ? (64'd0 - {48'd0, sp_cur})
                                                : {24'd0, prod - {24'd0, sp_cur}};
            d_in[sel_ff]    = REM_W'(prod + {24'd0, sp_cur});
            if (sel_ff) begin
               state_in = SEQ_IDLE;
            end else begin
               sel_in   = 1'b1;
               state_in = SEQ_LOAD;
            end
         end
         SEQ_IDLE: ;
         default: state_in = SEQ_LOAD;
      endcase
      if (csr_we) begin
         state_in = SEQ_LOAD;
         sel_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= RST_WORK_LIMIT;
         stake_ff <= RST_STAKE_LIMIT;
         sp1_ff   <= RST_SPACING;
         sp2_ff   <= RST_SPACING;
         span_ff  <= RST_TIMESPAN;
         state_ff <= SEQ_LOAD;
         sel_ff   <= 1'b0;
         cnt_ff   <= 5'd0;
      end else begin
         work_ff  <= work_in;
         stake_ff <= stake_in;
         sp1_ff   <= sp1_in;
         sp2_ff   <= sp2_in;
         span_ff  <= span_in;
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      base_ff <= base_in;
      d_ff    <= d_in;
   end

   assign cfg_ready       = (state_ff == SEQ_IDLE);
   assign cfg.work_limit  = work_ff;
   assign cfg.stake_limit = stake_ff;
   assign cfg.base        = base_ff;
   assign cfg.d           = d_ff;
   assign cfg.sp          = {sp_eff2, sp_eff1};

endmodule

`default_nettype wire

[hdl/crt_front.sv]
`default_nettype none

module crt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  req_fire,
   input  logic [1:0]            chain_position,
   input  logic                  stake_flag,
   input  logic                  version_two,
   input  logic [30:0]           last_height,
   input  logic [31:0]           prev_bits,
   input  logic [31:0]           prev_time,
   input  logic [31:0]           prev_prev_time,
   input  crt_pkg::crt_cfg_type  cfg,
   output crt_pkg::crt_stage_type head
);
   import crt_pkg::*;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic              hf;
      logic [MANT_W-1:0] m;
      logic [7:0]        sb;
      logic [MANT_W-1:0] lm;
      logic [7:0]        lsb;
      logic [32:0]       act;
      logic [63:0]       base;
      logic [REM_W-1:0]  d;
   } fa_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic              hf;
      logic [MANT_W-1:0] m;
      logic [7:0]        sb;
      logic [MANT_W-1:0] lm;
      logic [7:0]        lsb;
      logic [REM_W-1:0]  d;
      logic [63:0]       mult;
   } fb_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic              hf;
      logic [7:0]        sb;
      logic [MANT_W-1:0] lm;
      logic [7:0]        lsb;
      logic [REM_W-1:0]  d;
      logic [54:0]       plo;
      logic [54:0]       phi;
   } fc_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic              hf;
      logic [7:0]        sb;
      logic [MANT_W-1:0] lm;
      logic [7:0]        lsb;
      logic [REM_W-1:0]  d;
      logic [PROD_W-1:0] pt;
   } fd_type;

   fa_type        a_ff, a_in;
   fb_type        b_ff, b_in;
   fc_type        c_ff, c_in;
   fd_type        d_ff, d_in;
   crt_stage_type e_ff, e_in;

   function automatic logic [30:0] decode(input logic [31:0] bits);
      logic [7:0]        size;
      logic [MANT_W-1:0] word;
      logic [MANT_W-1:0] m;
      logic [7:0]        sb;
      size = bits[31:24];
      word = bits[22:0];
      m    = word;
      sb   = 8'd0;
      if (size <= 8'd3) begin
         unique case (size[1:0])
            2'd0: m = '0;
            2'd1: m = word >> 16;
            2'd2: m = word >> 8;
            2'd3: m = word;
         endcase
      end else begin
         sb = size - 8'd3;
      end
      return {sb, m};
   endfunction

   always_comb begin
      logic [31:0] limit;
      logic [15:0] sp;
      logic [30:0] dp;
      logic [30:0] dl;
      a_in       = '0;
      a_in.valid = req_fire;
      a_in.hf    = (last_height >= HEIGHT_SWITCH);
      limit      = stake_flag ? cfg.stake_limit : cfg.work_limit;
      unique case (chain_position)
         POS_NONE:              limit = cfg.work_limit;
         POS_FIRST, POS_SECOND: a_in.full = 1'b0;
         POS_FULL:              a_in.full = 1'b1;
      endcase
      sp        = cfg.sp[version_two];
      a_in.base = cfg.base[version_two];
      a_in.d    = cfg.d[version_two];
      dp        = decode(prev_bits);
      dl        = decode(limit);
      a_in.m    = dp[22:0];
      a_in.sb   = dp[30:23];
      a_in.lm   = dl[22:0];
      a_in.lsb  = dl[30:23];
      a_in.act  = {1'b0, prev_time} - {1'b0, prev_prev_time};
      if (a_in.hf && a_in.act[32]) begin
         a_in.act = {17'd0, sp};
      end
   end

   always_comb begin
      b_in.valid = a_ff.valid;
      b_in.full  = a_ff.full;
      b_in.hf    = a_ff.hf;
      b_in.m     = a_ff.m;
      b_in.sb    = a_ff.sb;
      b_in.lm    = a_ff.lm;
      b_in.lsb   = a_ff.lsb;
      b_in.d     = a_ff.d;
      b_in.mult  = a_ff.base + {{30{a_ff.act[32]}}, a_ff.act, 1'b0};
   end

   always_comb begin
      c_in.valid = b_ff.valid;
      c_in.full  = b_ff.full;
      c_in.hf    = b_ff.hf;
      c_in.sb    = b_ff.sb;
      c_in.lm    = b_ff.lm;
      c_in.lsb   = b_ff.lsb;
      c_in.d     = b_ff.d;
      c_in.plo   = b_ff.m * b_ff.mult[31:0];
      c_in.phi   = b_ff.m * b_ff.mult[63:32];
   end

   always_comb begin
      d_in.valid = c_ff.valid;
      d_in.full  = c_ff.full;
      d_in.hf    = c_ff.hf;
      d_in.sb    = c_ff.sb;
      d_in.lm    = c_ff.lm;
      d_in.lsb   = c_ff.lsb;
      d_in.d     = c_ff.d;
      d_in.pt    = {32'd0, c_ff.plo} + {c_ff.phi, 32'd0};
   end

   always_comb begin
      logic [10:0] shx;
      logic [10:0] shy;
      e_in       = '0;
      e_in.valid = d_ff.valid;
      e_in.full  = d_ff.full;
      e_in.hf    = d_ff.hf;
      e_in.d     = d_ff.d;
      shx        = {d_ff.sb, 3'b000} - 11'd169;
      shy        = {d_ff.lsb, 3'b000} - 11'd233;
      if (d_ff.sb <= 8'd21) begin
         e_in.gap = 8'd169 - {d_ff.sb[4:0], 3'b000};
         e_in.dv  = d_ff.pt;
      end else if (shx > 11'd86) begin
         e_in.dv  = '0;
      end else begin
         e_in.dv  = d_ff.pt << shx[6:0];
      end
      if (d_ff.lsb <= 8'd29) begin
         e_in.lgap = 8'd233 - {d_ff.lsb[4:0], 3'b000};
         e_in.lsr  = d_ff.lm;
      end else if (shy > 11'd22) begin
         e_in.lsr  = '0;
      end else begin
         e_in.lsr  = d_ff.lm << shy[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         d_ff.valid <= 1'b0;
         e_ff.valid <= 1'b0;
      end else if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   assign head = e_ff;

endmodule

`default_nettype wire

[hdl/crt_stage.sv]
`default_nettype none

module crt_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  crt_pkg::crt_stage_type prev,
   output crt_pkg::crt_stage_type next
);
   import crt_pkg::*;

   crt_stage_type s_ff, s_in;

   always_comb begin
      logic [7:0]       pos;
      logic             xb;
      logic             lb;
      logic             qb;
      logic [REM_W:0]   r;
      s_in = prev;
      for (int j = 0; j < BPS; j++) begin
         pos = 8'(TGT_W - 1 - BPS * STAGE_IDX - j);
         if (s_in.gap != 8'd0) begin
            xb       = 1'b0;
            s_in.gap = s_in.gap - 8'd1;
         end else begin
            xb      = s_in.dv[PROD_W-1];
            s_in.dv = {s_in.dv[PROD_W-2:0], 1'b0};
         end
         if (s_in.lgap != 8'd0) begin
            lb        = 1'b0;
            s_in.lgap = s_in.lgap - 8'd1;
         end else begin
            lb       = s_in.lsr[MANT_W-1];
            s_in.lsr = {s_in.lsr[MANT_W-2:0], 1'b0};
         end
         r = {s_in.rem, xb};
         if (r >= {1'b0, s_in.d}) begin
            qb = 1'b1;
            r  = r - {1'b0, s_in.d};
         end else begin
            qb = 1'b0;
         end
         s_in.rem = r[REM_W-1:0];
         if (!s_in.gt && !s_in.lt) begin
            s_in.gt = qb & ~lb;
            s_in.lt = lb & ~qb;
         end
         s_in.qtrk = trk_step(s_in.qtrk, qb, pos);
         s_in.ltrk = trk_step(s_in.ltrk, lb, pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff.valid <= 1'b0;
      end else if (en) begin
         s_ff <= s_in;
      end
   end

   assign next = s_ff;

endmodule

`default_nettype wire

[hdl/crt_tail.sv]
`default_nettype none

module crt_tail (
   input  logic                   clock,
   input  logic                   reset,
   input  crt_pkg::crt_stage_type last,
   output logic                   en,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_next_bits
);
   import crt_pkg::*;

   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] q0_ff, q0_in;
   logic [31:0] q1_ff, q1_in;
   logic [31:0] res;
   logic        push;
   logic        pop;
   logic        use_limit;

   assign en        = (cnt_ff != 2'd2);
   assign push      = en && last.valid;
   assign pop       = (cnt_ff != 2'd0) && rsp_ready;
   assign use_limit = !last.full || last.gt || (last.hf && !last.qtrk.started);
   assign res       = use_limit ? trk_encode(last.ltrk) : trk_encode(last.qtrk);

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      unique case (cnt_ff)
         2'd0: begin
            if (push) begin
               q0_in  = res;
               cnt_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               q0_in = res;
            end else if (push) begin
               q1_in  = res;
               cnt_in = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               q0_in  = q1_ff;
               cnt_in = 2'd1;
            end
         end
         default: cnt_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_next_bits = q0_ff;

endmodule

`default_nettype wire

[hdl/compact_target_retarget_top.sv]
`default_nettype none

// Next compact proof target from the previous target and the last two block
// times. One request per cycle enters while the output queue is not full and the
// configuration is ready; each result passes five setup stages, 128 long-division
// stages retiring two quotient bits each against a 25-bit divisor, and is encoded
// as it enters a two-entry output queue, where it waits. After reset and after any
// register write, req_ready stays low while a serial divider recomputes timespan /
// spacing for both protocol versions.
module compact_target_retarget_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_chain_position,
   input  logic        req_stake_flag,
   input  logic        req_version_two,
   input  logic [30:0] req_last_height,
   input  logic [31:0] req_prev_bits,
   input  logic [31:0] req_prev_time,
   input  logic [31:0] req_prev_prev_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_bits,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import crt_pkg::*;

   crt_cfg_type   cfg;
   logic          cfg_ready;
   logic          en;
   logic          req_fire;
   crt_stage_type chain [0:NSTAGE];

   assign req_ready = en && cfg_ready;
   assign req_fire  = req_valid && req_ready;

   crt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_ready (cfg_ready),
      .cfg       (cfg)
   );

   crt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .req_fire       (req_fire),
      .chain_position (req_chain_position),
      .stake_flag     (req_stake_flag),
      .version_two    (req_version_two),
      .last_height    (req_last_height),
      .prev_bits      (req_prev_bits),
      .prev_time      (req_prev_time),
      .prev_prev_time (req_prev_prev_time),
      .cfg            (cfg),
      .head           (chain[0])
   );

   for (genvar k = 0; k < NSTAGE; k++) begin : g_div
      crt_stage #(.STAGE_IDX(k)) u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .prev  (chain[k]),
         .next  (chain[k+1])
      );
   end

   crt_tail u_tail (
      .clock         (clock),
      .reset         (reset),
      .last          (chain[NSTAGE]),
      .en            (en),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_next_bits (rsp_next_bits)
   );

`ifndef SYNTHESIS
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request taken right after a register write");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      !en |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(chain[NSTAGE]))
      else $error("last division stage moved during stall");
`endif

endmodule

`default_nettype wire
